// ===== sv/fpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and codes for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  // default configuration
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  // item function codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_REQUEST = 2'd1;
  localparam logic [1:0] FUNC_FREE    = 2'd2;

  // fit modes (the unused code acts as first fit)
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_FIT_MODE      = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  slot;
    logic [15:0] amount;
  } in_word_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  block_index;
    logic [15:0] block_size;
    logic [15:0] fragment;
  } out_word_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       clear;
    logic       commit;
    logic [1:0] mode;
  } fpfa_bcast_t;

endpackage

// ===== sv/fixed_partition_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed partition table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
//   channel   ports                                   direction
//   item      start, busy, in_item                    in, start qualified by !busy
//   result    out_valid, out_item                     out, one-cycle strobe
//   config    psel, penable, pwrite, paddr, pwdata,   apb, pready tied high
//             prdata, pready
//
// a load or free word is taken without raising busy and the block stays ready
// a request runs with busy high: the best-so-far record walks one cell of the
// partition chain per cycle, the word lands in the cycle after the record
// leaves the last cell, busy drops the same cycle
// reset (rst_n low, synchronous) frees all partitions and clears fit_mode and
// blocks_in_use; partition sizes are undefined until loaded
// results cannot be held off: out_valid is high for exactly one cycle
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_item,
  // result channel
  output logic        out_valid,
  output out_word_t   out_item,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  // step count runs 0 .. NUM_BLOCKS, the record reaches the tail at the last
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_BLOCKS);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [SIZE_WIDTH-1:0] amount_r;
  logic [1:0]            fit_mode_r;
  logic [4:0]            blocks_r;
  logic                  out_valid_r;
  out_word_t             out_item_r;

  logic                  accept;
  logic                  cfg_write;
  logic                  commit;
  fpfa_bcast_t           bcast;
  logic [SIZE_WIDTH-1:0] load_size;
  logic [NUM_BLOCKS-1:0] take_part;
  logic [NUM_BLOCKS-1:0] load_en;

  // search chain links: link g feeds cell g, link NUM_BLOCKS is the tail
  logic                  found_c [0:NUM_BLOCKS];
  logic [IDX_W-1:0]      pick_c  [0:NUM_BLOCKS];
  logic [SIZE_WIDTH-1:0] size_c  [0:NUM_BLOCKS];

  assign busy      = (state_r == ST_SCAN);
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign commit    = busy && (cnt_r == LAST_STEP);
  assign load_size = SIZE_WIDTH'(in_item.amount);

  assign bcast.clear  = accept && (in_item.func == FUNC_FREE);
  assign bcast.commit = commit;
  assign bcast.mode   = fit_mode_r;

  // the chain head always starts with an empty record
  assign found_c[0] = 1'b0;
  assign pick_c[0]  = '0;
  assign size_c[0]  = '0;

  // register reads
  always_comb begin
    case (paddr[2])
      REG_FIT_MODE:      prdata = {30'd0, fit_mode_r};
      REG_BLOCKS_IN_USE: prdata = {27'd0, blocks_r};
      default:           prdata = '0;
    endcase
  end

  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    // blocks_in_use above the table size simply enables every cell
    assign take_part[g] = (g < int'(blocks_r));
    // slots beyond the table never match
    assign load_en[g]   = accept && (in_item.func == FUNC_LOAD) &&
                          (int'(in_item.slot) == g);

    fpfa_cell #(
      .SIZE_WIDTH (SIZE_WIDTH),
      .IDX_W      (IDX_W),
      .CELL_ID    (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .bcast        (bcast),
      .load_en      (load_en[g]),
      .load_size    (load_size),
      .take_part    (take_part[g]),
      .req_amount   (amount_r),
      .commit_pick  (pick_c[NUM_BLOCKS]),
      .commit_found (found_c[NUM_BLOCKS]),
      .found_in     (found_c[g]),
      .pick_in      (pick_c[g]),
      .size_in      (size_c[g]),
      .found_out    (found_c[g+1]),
      .pick_out     (pick_c[g+1]),
      .size_out     (size_c[g+1])
    );
  end

  // request amount holds steady while the record walks the chain
  always_ff @(posedge clk) begin
    if (accept && (in_item.func == FUNC_REQUEST)) begin
      amount_r <= SIZE_WIDTH'(in_item.amount);
    end
  end

  // sequencer, config registers, result word and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fit_mode_r  <= '0;
      blocks_r    <= '0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_write) begin
        case (paddr[2])
          REG_FIT_MODE:      fit_mode_r <= pwdata[1:0];
          REG_BLOCKS_IN_USE: blocks_r   <= pwdata[4:0];
          default:           ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_item.func == FUNC_REQUEST)) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          if (commit) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            if (found_c[NUM_BLOCKS]) begin
              out_item_r.granted     <= 1'b1;
              out_item_r.block_index <= 4'(pick_c[NUM_BLOCKS]);
              out_item_r.block_size  <= 16'(size_c[NUM_BLOCKS]);
              out_item_r.fragment    <= 16'(size_c[NUM_BLOCKS] - amount_r);
            end else begin
              out_item_r <= '0;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/fpfa_cell.sv =====
// ----------------------------------------------------------------------------
// fpfa_cell
// One partition: size, used mark and one stage of the fit search chain.
// ----------------------------------------------------------------------------
module fpfa_cell
  import fpfa_pkg::*;
#(
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF,
  parameter int IDX_W      = 4,
  parameter int CELL_ID    = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fpfa_bcast_t           bcast,
  input  logic                  load_en,
  input  logic [SIZE_WIDTH-1:0] load_size,
  input  logic                  take_part,
  input  logic [SIZE_WIDTH-1:0] req_amount,
  input  logic [IDX_W-1:0]      commit_pick,
  input  logic                  commit_found,
  input  logic                  found_in,
  input  logic [IDX_W-1:0]      pick_in,
  input  logic [SIZE_WIDTH-1:0] size_in,
  output logic                  found_out,
  output logic [IDX_W-1:0]      pick_out,
  output logic [SIZE_WIDTH-1:0] size_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

  logic [SIZE_WIDTH-1:0] size_r;
  logic                  used_r;
  logic                  found_r;
  logic [IDX_W-1:0]      pick_r;
  logic [SIZE_WIDTH-1:0] best_r;
  logic                  eligible;
  logic                  take;

  assign eligible = take_part && !used_r && (size_r >= req_amount);

  always_comb begin
    take = 1'b0;
    if (eligible) begin
      if (!found_in) begin
        take = 1'b1;
      end else begin
        case (bcast.mode)
          MODE_BEST:  take = (size_r < size_in);
          MODE_WORST: take = (size_r > size_in);
          default:    take = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      size_r <= load_size;
    end
    if (take) begin
      pick_r <= MY_IDX;
      best_r <= size_r;
    end else begin
      pick_r <= pick_in;
      best_r <= size_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      found_r <= found_in || take;
      if (bcast.clear) begin
        used_r <= 1'b0;
      end else if (bcast.commit && commit_found && (commit_pick == MY_IDX)) begin
        used_r <= 1'b1;
      end
    end
  end

  assign found_out = found_r;
  assign pick_out  = pick_r;
  assign size_out  = best_r;

endmodule

// ===== sv/fpfa_checker.sv =====
// ----------------------------------------------------------------------------
// fpfa_checker
// Port-level checks for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
module fpfa_checker
  import fpfa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_item,
  input logic      out_valid,
  input out_word_t out_item
);

  // a request word always starts a search
  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.func == FUNC_REQUEST) |=> busy)
    else $error("request word did not raise busy");

  // the result word lands exactly when the search ends
  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search ended without a result word");

  // no result word while a search is still running
  a_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word during a search");

  // a miss reports all zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.granted |->
      (out_item.block_index == 4'd0) && (out_item.block_size == 16'd0) &&
      (out_item.fragment == 16'd0))
    else $error("miss word carries nonzero fields");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
